// ===== design/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types, constants and helpers of the dirty tile tracker.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int TILE_PIXELS      = 64;
  localparam int TILE_SHIFT       = $clog2(TILE_PIXELS);
  localparam int MAX_TILE_COLUMNS = 64;
  localparam int MAX_TILE_ROWS    = 64;

  localparam int DIM_W   = 13;
  localparam int CNT_W   = 7;
  localparam int ROW_W   = 6;
  localparam int MASK_W  = 64;
  localparam int TOP_W   = 12;
  localparam int EXT_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  typedef enum logic [1:0] {
    CMD_MARK         = 2'd0,
    CMD_FLUSH_FRAME  = 2'd1,
    CMD_FLUSH_STROKE = 2'd2,
    CMD_ABORT        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_MARK_SETUP = 8'b0000_0010,
    S_MARK_RD    = 8'b0000_0100,
    S_MARK_WR    = 8'b0000_1000,
    S_FL_SCAN    = 8'b0001_0000,
    S_FL_RD      = 8'b0010_0000,
    S_FL_EMIT    = 8'b0100_0000,
    S_FL_LAST    = 8'b1000_0000
  } state_t;

  // ceil(pixels / tile) capped at the tile maximum
  function automatic logic [CNT_W-1:0] tile_count(input logic [DIM_W-1:0] pixels,
                                                  input logic [CNT_W-1:0] cap);
    logic [DIM_W:0] n;
    n = ((DIM_W+1)'(pixels) + (DIM_W+1)'(TILE_PIXELS - 1)) >> TILE_SHIFT;
    if (n > (DIM_W+1)'(cap)) begin
      tile_count = cap;
    end else begin
      tile_count = n[CNT_W-1:0];
    end
  endfunction

  // lower n bits set, all ones from 64 up
  function automatic logic [MASK_W-1:0] column_mask(input logic [CNT_W-1:0] n);
    logic [MASK_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    column_mask = m;
  endfunction

endpackage

// ===== design/dirty_tile_tracker.sv =====
// ----------------------------------------------------------------------------
// dirty_tile_tracker
// Frame and stroke bitmaps of dirtied 64-pixel tiles, one word per tile row.
// ----------------------------------------------------------------------------
// Input items arrive on in_* (valid/ready) and carry a command: mark a pixel
// rectangle into both maps, flush the frame or the stroke map, or abort.
// in_ready is high only while the sequencer is idle; one item at a time.
// A mark passes a setup state, then reads and writes back the row word of
// each tile row touched; it gives no result.
// A flush scans all 64 row slots in turn, reads the row word of each dirty
// row and hands each result over to the output register, holding while
// out_ready is low and the register is full.
// Each dirty row gives one out_* item; an empty map gives a single item with
// out_map_empty set. out_last marks the final item of a flush. Results wait
// in the output register while the receiver stalls; the sequencer holds
// until the register is free. Abort clears both maps in the accept cycle.
// cfg_* writes set the canvas size; a changed value clears both maps.
// The row words live in two 64-entry memories; per-row valid bits stand in
// for their contents after reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module dirty_tile_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic signed [15:0]                  in_rect_x,
  input  logic signed [15:0]                  in_rect_y,
  input  logic [15:0]                         in_rect_width,
  input  logic [15:0]                         in_rect_height,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_map_select,
  output logic [dtt_pkg::ROW_W-1:0]           out_row_index,
  output logic [dtt_pkg::MASK_W-1:0]          out_row_mask,
  output logic [dtt_pkg::TOP_W-1:0]           out_row_pixel_top,
  output logic [dtt_pkg::EXT_W-1:0]           out_row_pixel_height,
  output logic [dtt_pkg::EXT_W-1:0]           out_last_column_width,
  output logic                                out_map_empty,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [dtt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtt_pkg::DIM_W-1:0]           cfg_wdata
);

  localparam int ROWS = dtt_pkg::MAX_TILE_ROWS;
  localparam int SH   = dtt_pkg::TILE_SHIFT;

  dtt_pkg::state_t state_r, state_nxt;

  logic [dtt_pkg::DIM_W-1:0]  width_r, width_nxt;
  logic [dtt_pkg::DIM_W-1:0]  height_r, height_nxt;
  logic [ROWS-1:0]            frame_vld_r, frame_vld_nxt;
  logic [ROWS-1:0]            stroke_vld_r, stroke_vld_nxt;
  logic                       sel_r, sel_nxt;
  logic [14:0]                x_r, x_nxt;
  logic [14:0]                y_r, y_nxt;
  logic [15:0]                w_r, w_nxt;
  logic [15:0]                h_r, h_nxt;
  logic [dtt_pkg::CNT_W-1:0]  row_r, row_nxt;
  logic [dtt_pkg::CNT_W-1:0]  ty1_r, ty1_nxt;
  logic [dtt_pkg::MASK_W-1:0] span_r, span_nxt;
  logic                       have_pend_r, have_pend_nxt;
  logic [dtt_pkg::ROW_W-1:0]  pend_row_r, pend_row_nxt;
  logic [dtt_pkg::MASK_W-1:0] pend_mask_r, pend_mask_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       o_sel_r, o_sel_nxt;
  logic [dtt_pkg::ROW_W-1:0]  o_row_r, o_row_nxt;
  logic [dtt_pkg::MASK_W-1:0] o_mask_r, o_mask_nxt;
  logic [dtt_pkg::TOP_W-1:0]  o_top_r, o_top_nxt;
  logic [dtt_pkg::EXT_W-1:0]  o_hgt_r, o_hgt_nxt;
  logic [dtt_pkg::EXT_W-1:0]  o_lastw_r, o_lastw_nxt;
  logic                       o_empty_r, o_empty_nxt;
  logic                       o_last_r, o_last_nxt;

  // row memories
  logic [dtt_pkg::MASK_W-1:0] frame_mem [ROWS];
  logic [dtt_pkg::MASK_W-1:0] stroke_mem [ROWS];
  logic [dtt_pkg::MASK_W-1:0] frame_rd_r, stroke_rd_r;
  logic                       mem_re, mem_we;
  logic [dtt_pkg::ROW_W-1:0]  mem_addr;
  logic [dtt_pkg::MASK_W-1:0] frame_wdata, stroke_wdata;

  // derived canvas values
  logic [dtt_pkg::CNT_W-1:0]  cols, rows;
  logic [dtt_pkg::DIM_W:0]    right_px, left_px;
  logic [dtt_pkg::EXT_W-1:0]  lastw;
  logic [dtt_pkg::TOP_W-1:0]  pend_top;
  logic [dtt_pkg::DIM_W:0]    pend_bot;
  logic [dtt_pkg::EXT_W-1:0]  pend_hgt;

  // mark setup
  logic [16:0]                x_end, y_end;
  logic [8:0]                 tx0, ty0;
  logic [10:0]                tx1, ty1;
  logic [dtt_pkg::CNT_W-1:0]  tx1c, ty1c;

  logic                       in_acc, slot_free, cur_vld;
  logic [dtt_pkg::MASK_W-1:0] rd_row;

  assign in_ready  = (state_r == dtt_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign cols = dtt_pkg::tile_count(width_r, dtt_pkg::CNT_W'(dtt_pkg::MAX_TILE_COLUMNS));
  assign rows = dtt_pkg::tile_count(height_r, dtt_pkg::CNT_W'(dtt_pkg::MAX_TILE_ROWS));

  always_comb begin
    right_px = (dtt_pkg::DIM_W+1)'(cols) << SH;
    left_px  = ((dtt_pkg::DIM_W+1)'(cols) - (dtt_pkg::DIM_W+1)'(1)) << SH;
    if (right_px > (dtt_pkg::DIM_W+1)'(width_r)) begin
      right_px = (dtt_pkg::DIM_W+1)'(width_r);
    end
    if (cols == '0) begin
      lastw = '0;
    end else begin
      lastw = dtt_pkg::EXT_W'(right_px - left_px);
    end
  end

  always_comb begin
    pend_top = {pend_row_r, {SH{1'b0}}};
    pend_bot = (dtt_pkg::DIM_W+1)'(pend_top) + (dtt_pkg::DIM_W+1)'(dtt_pkg::TILE_PIXELS);
    if (pend_bot > (dtt_pkg::DIM_W+1)'(height_r)) begin
      pend_bot = (dtt_pkg::DIM_W+1)'(height_r);
    end
    pend_hgt = dtt_pkg::EXT_W'(pend_bot - (dtt_pkg::DIM_W+1)'(pend_top));
  end

  always_comb begin
    x_end = 17'(x_r) + 17'(w_r) + 17'(dtt_pkg::TILE_PIXELS - 1);
    y_end = 17'(y_r) + 17'(h_r) + 17'(dtt_pkg::TILE_PIXELS - 1);
    tx0   = x_r[14:SH];
    ty0   = y_r[14:SH];
    tx1   = x_end[16:SH];
    ty1   = y_end[16:SH];
    tx1c  = (tx1 > 11'(cols)) ? cols : tx1[dtt_pkg::CNT_W-1:0];
    ty1c  = (ty1 > 11'(rows)) ? rows : ty1[dtt_pkg::CNT_W-1:0];
  end

  assign cur_vld = sel_r ? stroke_vld_r[row_r[dtt_pkg::ROW_W-1:0]]
                         : frame_vld_r[row_r[dtt_pkg::ROW_W-1:0]];
  assign rd_row  = sel_r ? stroke_rd_r : frame_rd_r;

  always_comb begin
    state_nxt      = state_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    frame_vld_nxt  = frame_vld_r;
    stroke_vld_nxt = stroke_vld_r;
    sel_nxt        = sel_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    row_nxt        = row_r;
    ty1_nxt        = ty1_r;
    span_nxt       = span_r;
    have_pend_nxt  = have_pend_r;
    pend_row_nxt   = pend_row_r;
    pend_mask_nxt  = pend_mask_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_sel_nxt      = o_sel_r;
    o_row_nxt      = o_row_r;
    o_mask_nxt     = o_mask_r;
    o_top_nxt      = o_top_r;
    o_hgt_nxt      = o_hgt_r;
    o_lastw_nxt    = o_lastw_r;
    o_empty_nxt    = o_empty_r;
    o_last_nxt     = o_last_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = row_r[dtt_pkg::ROW_W-1:0];
    frame_wdata    = (frame_vld_r[mem_addr] ? frame_rd_r : '0) | span_r;
    stroke_wdata   = (stroke_vld_r[mem_addr] ? stroke_rd_r : '0) | span_r;

    unique case (state_r)
      dtt_pkg::S_IDLE: begin
        if (in_acc) begin
          x_nxt = in_rect_x[15] ? '0 : in_rect_x[14:0];
          y_nxt = in_rect_y[15] ? '0 : in_rect_y[14:0];
          w_nxt = in_rect_width;
          h_nxt = in_rect_height;
          unique case (dtt_pkg::cmd_t'(in_command))
            dtt_pkg::CMD_MARK: begin
              state_nxt = dtt_pkg::S_MARK_SETUP;
            end
            dtt_pkg::CMD_FLUSH_FRAME, dtt_pkg::CMD_FLUSH_STROKE: begin
              sel_nxt       = (dtt_pkg::cmd_t'(in_command) == dtt_pkg::CMD_FLUSH_STROKE);
              row_nxt       = '0;
              have_pend_nxt = 1'b0;
              state_nxt     = dtt_pkg::S_FL_SCAN;
            end
            default: begin
              frame_vld_nxt  = '0;
              stroke_vld_nxt = '0;
            end
          endcase
        end
      end
      dtt_pkg::S_MARK_SETUP: begin
        span_nxt = dtt_pkg::column_mask(tx1c) &
                   ~dtt_pkg::column_mask(tx0[dtt_pkg::CNT_W-1:0]);
        row_nxt  = ty0[dtt_pkg::CNT_W-1:0];
        ty1_nxt  = ty1c;
        if ((9'(tx1c) <= tx0) || (9'(ty1c) <= ty0)) begin
          state_nxt = dtt_pkg::S_IDLE;
        end else begin
          state_nxt = dtt_pkg::S_MARK_RD;
        end
      end
      dtt_pkg::S_MARK_RD: begin
        mem_re    = 1'b1;
        state_nxt = dtt_pkg::S_MARK_WR;
      end
      dtt_pkg::S_MARK_WR: begin
        mem_we                   = 1'b1;
        frame_vld_nxt[mem_addr]  = 1'b1;
        stroke_vld_nxt[mem_addr] = 1'b1;
        row_nxt                  = row_r + dtt_pkg::CNT_W'(1);
        if (row_nxt == ty1_r) begin
          state_nxt = dtt_pkg::S_IDLE;
        end else begin
          state_nxt = dtt_pkg::S_MARK_RD;
        end
      end
      dtt_pkg::S_FL_SCAN: begin
        if (row_r == dtt_pkg::CNT_W'(ROWS)) begin
          state_nxt = dtt_pkg::S_FL_LAST;
        end else if (cur_vld) begin
          mem_re    = 1'b1;
          state_nxt = dtt_pkg::S_FL_RD;
        end else begin
          row_nxt = row_r + dtt_pkg::CNT_W'(1);
        end
      end
      dtt_pkg::S_FL_RD: begin
        if (have_pend_r) begin
          state_nxt = dtt_pkg::S_FL_EMIT;
        end else begin
          have_pend_nxt = 1'b1;
          pend_row_nxt  = row_r[dtt_pkg::ROW_W-1:0];
          pend_mask_nxt = rd_row;
          row_nxt       = row_r + dtt_pkg::CNT_W'(1);
          state_nxt     = dtt_pkg::S_FL_SCAN;
        end
      end
      dtt_pkg::S_FL_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_sel_nxt     = sel_r;
          o_row_nxt     = pend_row_r;
          o_mask_nxt    = pend_mask_r;
          o_top_nxt     = pend_top;
          o_hgt_nxt     = pend_hgt;
          o_lastw_nxt   = lastw;
          o_empty_nxt   = 1'b0;
          o_last_nxt    = 1'b0;
          pend_row_nxt  = row_r[dtt_pkg::ROW_W-1:0];
          pend_mask_nxt = rd_row;
          row_nxt       = row_r + dtt_pkg::CNT_W'(1);
          state_nxt     = dtt_pkg::S_FL_SCAN;
        end
      end
      dtt_pkg::S_FL_LAST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_sel_nxt     = sel_r;
          o_lastw_nxt   = lastw;
          o_last_nxt    = 1'b1;
          if (have_pend_r) begin
            o_row_nxt   = pend_row_r;
            o_mask_nxt  = pend_mask_r;
            o_top_nxt   = pend_top;
            o_hgt_nxt   = pend_hgt;
            o_empty_nxt = 1'b0;
          end else begin
            o_row_nxt   = '0;
            o_mask_nxt  = '0;
            o_top_nxt   = '0;
            o_hgt_nxt   = '0;
            o_empty_nxt = 1'b1;
          end
          if (sel_r) begin
            stroke_vld_nxt = '0;
          end else begin
            frame_vld_nxt = '0;
          end
          state_nxt = dtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dtt_pkg::S_IDLE;
      end
    endcase

    // canvas size change clears both maps
    if (cfg_we) begin
      if (cfg_index == dtt_pkg::CFG_IMAGE_WIDTH) begin
        if (cfg_wdata != width_r) begin
          frame_vld_nxt  = '0;
          stroke_vld_nxt = '0;
        end
        width_nxt = cfg_wdata;
      end else begin
        if (cfg_wdata != height_r) begin
          frame_vld_nxt  = '0;
          stroke_vld_nxt = '0;
        end
        height_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dtt_pkg::S_IDLE;
      width_r      <= dtt_pkg::DIM_RESET;
      height_r     <= dtt_pkg::DIM_RESET;
      frame_vld_r  <= '0;
      stroke_vld_r <= '0;
      have_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      row_r        <= '0;
      ty1_r        <= '0;
      sel_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      frame_vld_r  <= frame_vld_nxt;
      stroke_vld_r <= stroke_vld_nxt;
      have_pend_r  <= have_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      row_r        <= row_nxt;
      ty1_r        <= ty1_nxt;
      sel_r        <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    span_r      <= span_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_mask_r <= pend_mask_nxt;
    o_sel_r     <= o_sel_nxt;
    o_row_r     <= o_row_nxt;
    o_mask_r    <= o_mask_nxt;
    o_top_r     <= o_top_nxt;
    o_hgt_r     <= o_hgt_nxt;
    o_lastw_r   <= o_lastw_nxt;
    o_empty_r   <= o_empty_nxt;
    o_last_r    <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr]  <= frame_wdata;
      stroke_mem[mem_addr] <= stroke_wdata;
    end
    if (mem_re) begin
      frame_rd_r  <= frame_mem[mem_addr];
      stroke_rd_r <= stroke_mem[mem_addr];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_map_select        = o_sel_r;
  assign out_row_index         = o_row_r;
  assign out_row_mask          = o_mask_r;
  assign out_row_pixel_top     = o_top_r;
  assign out_row_pixel_height  = o_hgt_r;
  assign out_last_column_width = o_lastw_r;
  assign out_map_empty         = o_empty_r;
  assign out_last              = o_last_r;

endmodule

// ===== bench/tb_dirty_tile_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dirty_tile_tracker
// Self-checking bench for the frame and stroke dirty tile maps.
// ----------------------------------------------------------------------------
// Marks, flushes and aborts are driven on the in_* channel while the canvas
// size is changed between phases. A scoreboard keeps its own copy of both
// maps, predicts the row items of every flush and checks each out_* item
// against the oldest prediction. Both channels idle at random, and one phase
// holds the result channel off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_dirty_tile_tracker;

  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 47;
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  typedef struct packed {
    logic                       map_select;
    logic [dtt_pkg::ROW_W-1:0]  row_index;
    logic [dtt_pkg::MASK_W-1:0] row_mask;
    logic [dtt_pkg::TOP_W-1:0]  pixel_top;
    logic [dtt_pkg::EXT_W-1:0]  pixel_height;
    logic [dtt_pkg::EXT_W-1:0]  last_col_width;
    logic                       map_empty;
    logic                       last;
  } tile_row_t;

  class tile_flush_scoreboard;
    logic [dtt_pkg::MASK_W-1:0] frame_rows [dtt_pkg::MAX_TILE_ROWS];
    logic [dtt_pkg::MASK_W-1:0] stroke_rows [dtt_pkg::MAX_TILE_ROWS];
    int canvas_w;
    int canvas_h;
    tile_row_t expected_rows [$];
    int mismatches;

    function new();
      clear_maps();
      canvas_w = int'(dtt_pkg::DIM_RESET);
      canvas_h = int'(dtt_pkg::DIM_RESET);
      mismatches = 0;
    endfunction

    function void clear_maps();
      foreach (frame_rows[r]) begin
        frame_rows[r] = '0;
        stroke_rows[r] = '0;
      end
    endfunction

    function int tiles(int pixels, int cap);
      int n;
      n = (pixels + dtt_pkg::TILE_PIXELS - 1) / dtt_pkg::TILE_PIXELS;
      return (n > cap) ? cap : n;
    endfunction

    function logic [dtt_pkg::MASK_W-1:0] span_mask(int n);
      if (n >= dtt_pkg::MASK_W) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    function void mark_rect(logic signed [15:0] x, logic signed [15:0] y,
                            logic [15:0] w, logic [15:0] h);
      int x0, y0, tx0, ty0, tx1, ty1, cols, rows;
      logic [dtt_pkg::MASK_W-1:0] span;
      cols = tiles(canvas_w, dtt_pkg::MAX_TILE_COLUMNS);
      rows = tiles(canvas_h, dtt_pkg::MAX_TILE_ROWS);
      x0 = (x < 0) ? 0 : int'(x);
      y0 = (y < 0) ? 0 : int'(y);
      tx0 = x0 / dtt_pkg::TILE_PIXELS;
      ty0 = y0 / dtt_pkg::TILE_PIXELS;
      tx1 = (x0 + int'(w) + dtt_pkg::TILE_PIXELS - 1) / dtt_pkg::TILE_PIXELS;
      ty1 = (y0 + int'(h) + dtt_pkg::TILE_PIXELS - 1) / dtt_pkg::TILE_PIXELS;
      if (tx1 > cols) tx1 = cols;
      if (ty1 > rows) ty1 = rows;
      if (tx1 <= tx0 || ty1 <= ty0) return;
      span = span_mask(tx1) & ~span_mask(tx0);
      for (int r = ty0; r < ty1; r++) begin
        frame_rows[r] |= span;
        stroke_rows[r] |= span;
      end
    endfunction

    function void flush_map(logic sel);
      tile_row_t found [$];
      tile_row_t row;
      int cols, rows, top, bot, right;
      logic [dtt_pkg::MASK_W-1:0] cmask, m;
      logic [dtt_pkg::EXT_W-1:0] lastw;
      cols = tiles(canvas_w, dtt_pkg::MAX_TILE_COLUMNS);
      rows = tiles(canvas_h, dtt_pkg::MAX_TILE_ROWS);
      cmask = span_mask(cols);
      lastw = '0;
      if (cols > 0) begin
        right = cols * dtt_pkg::TILE_PIXELS;
        if (right > canvas_w) right = canvas_w;
        lastw = dtt_pkg::EXT_W'(right - (cols - 1) * dtt_pkg::TILE_PIXELS);
      end
      for (int r = 0; r < rows; r++) begin
        m = (sel ? stroke_rows[r] : frame_rows[r]) & cmask;
        if (m != '0) begin
          top = r * dtt_pkg::TILE_PIXELS;
          bot = top + dtt_pkg::TILE_PIXELS;
          if (bot > canvas_h) bot = canvas_h;
          row = '0;
          row.map_select = sel;
          row.row_index = dtt_pkg::ROW_W'(r);
          row.row_mask = m;
          row.pixel_top = dtt_pkg::TOP_W'(top);
          row.pixel_height = dtt_pkg::EXT_W'(bot - top);
          row.last_col_width = lastw;
          found.push_back(row);
        end
      end
      if (found.size() == 0) begin
        row = '0;
        row.map_select = sel;
        row.last_col_width = lastw;
        row.map_empty = 1'b1;
        row.last = 1'b1;
        found.push_back(row);
      end else begin
        found[found.size() - 1].last = 1'b1;
      end
      foreach (found[i]) expected_rows.push_back(found[i]);
      foreach (frame_rows[r]) begin
        if (sel) stroke_rows[r] = '0;
        else frame_rows[r] = '0;
      end
    endfunction

    function void apply_command(dtt_pkg::cmd_t cmd,
                                logic signed [15:0] x, logic signed [15:0] y,
                                logic [15:0] w, logic [15:0] h);
      unique case (cmd)
        dtt_pkg::CMD_MARK: begin
          mark_rect(x, y, w, h);
        end
        dtt_pkg::CMD_FLUSH_FRAME: begin
          flush_map(1'b0);
        end
        dtt_pkg::CMD_FLUSH_STROKE: begin
          flush_map(1'b1);
        end
        default: begin
          clear_maps();
        end
      endcase
    endfunction

    function void write_register(dtt_pkg::cfg_idx_t idx,
                                 logic [dtt_pkg::DIM_W-1:0] value);
      if (idx == dtt_pkg::CFG_IMAGE_WIDTH) begin
        if (int'(value) != canvas_w) clear_maps();
        canvas_w = int'(value);
      end else begin
        if (int'(value) != canvas_h) clear_maps();
        canvas_h = int'(value);
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_row(tile_row_t got);
      tile_row_t want;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual row %0d mask %0h",
                 $time, got.row_index, got.row_mask);
        mismatches++;
        return;
      end
      want = expected_rows.pop_front();
      compare_field("map_select", 64'(want.map_select), 64'(got.map_select));
      compare_field("row_index", 64'(want.row_index), 64'(got.row_index));
      compare_field("row_mask", want.row_mask, got.row_mask);
      compare_field("row_pixel_top", 64'(want.pixel_top), 64'(got.pixel_top));
      compare_field("row_pixel_height", 64'(want.pixel_height), 64'(got.pixel_height));
      compare_field("last_column_width", 64'(want.last_col_width), 64'(got.last_col_width));
      compare_field("map_empty", 64'(want.map_empty), 64'(got.map_empty));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic [1:0]                       in_command;
  logic signed [15:0]               in_rect_x;
  logic signed [15:0]               in_rect_y;
  logic [15:0]                      in_rect_width;
  logic [15:0]                      in_rect_height;
  logic                             out_valid;
  logic                             out_ready;
  logic                             out_map_select;
  logic [dtt_pkg::ROW_W-1:0]        out_row_index;
  logic [dtt_pkg::MASK_W-1:0]       out_row_mask;
  logic [dtt_pkg::TOP_W-1:0]        out_row_pixel_top;
  logic [dtt_pkg::EXT_W-1:0]        out_row_pixel_height;
  logic [dtt_pkg::EXT_W-1:0]        out_last_column_width;
  logic                             out_map_empty;
  logic                             out_last;
  logic                             cfg_we;
  logic [dtt_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [dtt_pkg::DIM_W-1:0]        cfg_wdata;

  tile_flush_scoreboard sb;
  bit        tx_idle_en;
  logic      rx_idle_en;
  logic      hold_toggle;
  logic      hold_seen;
  int        hold_left;
  tile_row_t seen_row;

  dirty_tile_tracker u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_rect_x             (in_rect_x),
    .in_rect_y             (in_rect_y),
    .in_rect_width         (in_rect_width),
    .in_rect_height        (in_rect_height),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_map_select        (out_map_select),
    .out_row_index         (out_row_index),
    .out_row_mask          (out_row_mask),
    .out_row_pixel_top     (out_row_pixel_top),
    .out_row_pixel_height  (out_row_pixel_height),
    .out_last_column_width (out_last_column_width),
    .out_map_empty         (out_map_empty),
    .out_last              (out_last),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen <= hold_toggle;
      hold_left <= 0;
      out_ready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_en) begin
      out_ready <= ($urandom_range(99) >= 33);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_row.map_select = out_map_select;
      seen_row.row_index = out_row_index;
      seen_row.row_mask = out_row_mask;
      seen_row.pixel_top = out_row_pixel_top;
      seen_row.pixel_height = out_row_pixel_height;
      seen_row.last_col_width = out_last_column_width;
      seen_row.map_empty = out_map_empty;
      seen_row.last = out_last;
      sb.check_row(seen_row);
    end
  end

  task automatic send_item(dtt_pkg::cmd_t cmd,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic [15:0] w, logic [15:0] h);
    while (tx_idle_en && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_rect_x <= x;
    in_rect_y <= y;
    in_rect_width <= w;
    in_rect_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_command(cmd, x, y, w, h);
  endtask

  task automatic send_random();
    int r, cw, ch;
    dtt_pkg::cmd_t cmd;
    logic signed [15:0] x, y;
    logic [15:0] w, h;
    cw = sb.canvas_w;
    ch = sb.canvas_h;
    r = $urandom_range(99);
    x = 16'($urandom);
    y = 16'($urandom);
    w = 16'($urandom);
    h = 16'($urandom);
    if (r < 50) begin
      // rectangle near the canvas, mostly small
      cmd = dtt_pkg::CMD_MARK;
      x = 16'(int'($urandom_range(0, cw + 96)) - 32);
      y = 16'(int'($urandom_range(0, ch + 96)) - 32);
      w = 16'($urandom_range(0, ($urandom_range(3) == 0) ? cw + 64 : 160));
      h = 16'($urandom_range(0, ($urandom_range(3) == 0) ? ch + 64 : 160));
    end else if (r < 60) begin
      cmd = dtt_pkg::CMD_MARK;
    end else if (r < 78) begin
      cmd = dtt_pkg::CMD_FLUSH_FRAME;
    end else if (r < 95) begin
      cmd = dtt_pkg::CMD_FLUSH_STROKE;
    end else begin
      cmd = dtt_pkg::CMD_ABORT;
    end
    send_item(cmd, x, y, w, h);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(dtt_pkg::cfg_idx_t idx, logic [dtt_pkg::DIM_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_canvas(int w, int h);
    write_reg(dtt_pkg::CFG_IMAGE_WIDTH, dtt_pkg::DIM_W'(w));
    write_reg(dtt_pkg::CFG_IMAGE_HEIGHT, dtt_pkg::DIM_W'(h));
  endtask

  task automatic run_phase(int w, int h, bit squeeze);
    set_canvas(w, h);
    if (squeeze) hold_toggle <= ~hold_toggle;
    repeat (PHASE_ITEMS) send_random();
  endtask

  initial begin
    sb = new();
    tx_idle_en = 1'b1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= dtt_pkg::CMD_MARK;
    in_rect_x <= '0;
    in_rect_y <= '0;
    in_rect_width <= '0;
    in_rect_height <= '0;
    cfg_we <= 1'b0;
    cfg_index <= dtt_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    rx_idle_en <= 1'b1;
    hold_toggle <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty maps, clamped corners, spans and full coverage
    send_item(dtt_pkg::CMD_FLUSH_FRAME, 16'h1234, -16'sd7, 16'hFFFF, 16'h0000);
    send_item(dtt_pkg::CMD_FLUSH_STROKE, -16'sd1, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_item(dtt_pkg::CMD_MARK, -16'sd32768, -16'sd32768, 16'd0, 16'd0);
    send_item(dtt_pkg::CMD_MARK, -16'sd5, -16'sd5, 16'd1, 16'd1);
    send_item(dtt_pkg::CMD_MARK, 16'sd32767, 16'sd32767, 16'hFFFF, 16'hFFFF);
    send_item(dtt_pkg::CMD_MARK, 16'sd63, 16'sd64, 16'd2, 16'd1);
    send_item(dtt_pkg::CMD_MARK, 16'sd4095, 16'sd4095, 16'd1, 16'd1);
    send_item(dtt_pkg::CMD_FLUSH_FRAME, '0, '0, '0, '0);
    send_item(dtt_pkg::CMD_MARK, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF);
    send_item(dtt_pkg::CMD_FLUSH_STROKE, '0, '0, '0, '0);
    send_item(dtt_pkg::CMD_FLUSH_FRAME, '0, '0, '0, '0);
    send_item(dtt_pkg::CMD_MARK, 16'sd100, 16'sd200, 16'd64, 16'd64);
    send_item(dtt_pkg::CMD_ABORT, -16'sd1, -16'sd1, 16'hFFFF, 16'hFFFF);
    send_item(dtt_pkg::CMD_FLUSH_FRAME, '0, '0, '0, '0);
    send_item(dtt_pkg::CMD_MARK, 16'sd128, 16'sd0, 16'd0, 16'd64);

    // clipped extents on an odd canvas
    set_canvas(100, 130);
    send_item(dtt_pkg::CMD_MARK, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF);
    send_item(dtt_pkg::CMD_FLUSH_FRAME, '0, '0, '0, '0);
    // same value keeps the maps, a new value clears them
    send_item(dtt_pkg::CMD_MARK, 16'sd64, 16'sd64, 16'd1, 16'd1);
    write_reg(dtt_pkg::CFG_IMAGE_WIDTH, 13'd100);
    send_item(dtt_pkg::CMD_FLUSH_STROKE, '0, '0, '0, '0);
    send_item(dtt_pkg::CMD_MARK, 16'sd0, 16'sd0, 16'd10, 16'd10);
    write_reg(dtt_pkg::CFG_IMAGE_WIDTH, 13'd99);
    send_item(dtt_pkg::CMD_FLUSH_FRAME, '0, '0, '0, '0);

    // zero-sized and oversized canvas
    set_canvas(0, 4096);
    send_item(dtt_pkg::CMD_MARK, 16'sd0, 16'sd0, 16'd100, 16'd100);
    send_item(dtt_pkg::CMD_FLUSH_FRAME, '0, '0, '0, '0);
    set_canvas(8191, 0);
    send_item(dtt_pkg::CMD_MARK, 16'sd0, 16'sd0, 16'd100, 16'd100);
    send_item(dtt_pkg::CMD_FLUSH_STROKE, '0, '0, '0, '0);
    set_canvas(8191, 8191);
    send_item(dtt_pkg::CMD_MARK, 16'sd4000, 16'sd4000, 16'd200, 16'd200);
    send_item(dtt_pkg::CMD_FLUSH_FRAME, '0, '0, '0, '0);

    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 1'b0);
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    run_phase(4096, 4096, 1'b1);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    run_phase(1, 1, 1'b0);
    run_phase(8191, 8191, 1'b0);
    run_phase($urandom_range(0, 8191), 0, 1'b0);
    run_phase($urandom_range(65, 640), $urandom_range(65, 640), 1'b0);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
